### design/pcx_rle_pkg.sv
// Shared types and constants for the PCX run-length pixel decoder.
// No dependencies; every other design file refers to this package by scoped names.
package pcx_rle_pkg;

  // Default geometry limits handed to the top level.
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  // Field widths fixed by the stream format.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned ADDR_W   = 20;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned CFG_IDX_W = 1;

  // Run header marker and count mask.
  localparam logic [BYTE_W-1:0] RUN_MARK       = 8'hC0;
  localparam logic [BYTE_W-1:0] RUN_COUNT_MASK = 8'h3F;

  // Depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  // Raw configuration register contents.
  typedef struct packed {
    logic [CFG_W-1:0] image_width;
    logic [CFG_W-1:0] image_height;
  } cfg_t;

  // One input request.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              start_of_image;
  } in_item_t;

  // One pixel write.
  typedef struct packed {
    logic [ADDR_W-1:0] pixel_address;
    logic [BYTE_W-1:0] pixel_value;
    logic              run_last;
    logic              image_done;
  } out_item_t;

  // Classified byte passed from front to back.
  typedef struct packed {
    logic               start;
    logic               is_mark;
    logic [COUNT_W-1:0] count;
    logic [BYTE_W-1:0]  value;
  } cmd_t;

  // Queue status seen by its producer and consumer.
  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

### design/pcx_rle_pixel_decoder.sv
// A byte is stored in the command queue, and its first pixel write leaves through the
// back part's output register. While the output does not stall, literal bytes pass at
// one byte per cycle; a run header only sets the pending count, and its value byte then
// emits one pixel write per cycle for each pixel of the run (1 to 63), or none when the
// count is zero. The emit loop in the back part holds its write while the output stalls.
// Reset: asynchronous, active low; registers return to width 1 and height 1,
// and the decoder ignores bytes until the first start of image.
module pcx_rle_pixel_decoder #(
  parameter int unsigned MAX_WIDTH  = pcx_rle_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = pcx_rle_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pcx_rle_pkg::in_item_t               in_item_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  output pcx_rle_pkg::out_item_t              out_item_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pcx_rle_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pcx_rle_pkg::CFG_W-1:0]       cfg_data_i
);

  pcx_rle_pkg::cfg_t          cfg_q, cfg_d;
  pcx_rle_pkg::cmd_t          push_cmd, pop_cmd;
  pcx_rle_pkg::queue_status_t q_status;
  logic                       push, pop;

  // Take a register write every cycle.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (pcx_rle_pkg::cfg_idx_e'(cfg_index_i))
        pcx_rle_pkg::CFG_IMAGE_WIDTH:  cfg_d.image_width  = cfg_data_i;
        pcx_rle_pkg::CFG_IMAGE_HEIGHT: cfg_d.image_height = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= pcx_rle_pkg::CFG_W'(1);
      cfg_q.image_height <= pcx_rle_pkg::CFG_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pcx_rle_front u_front (
    .in_item_i  (in_item_i),
    .in_valid_i (in_valid_i),
    .q_status_i (q_status),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  pcx_rle_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .cmd_o    (pop_cmd),
    .status_o (q_status)
  );

  pcx_rle_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (pop_cmd),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule

### design/pcx_rle_front.sv
// Front part of the PCX decoder: accepts stream bytes and classifies them.
// Depends on pcx_rle_pkg; feeds pcx_rle_queue.
module pcx_rle_front (
  input  pcx_rle_pkg::in_item_t      in_item_i,
  input  logic                       in_valid_i,
  input  pcx_rle_pkg::queue_status_t q_status_i,
  output logic                       in_stall_o,
  output logic                       push_o,
  output pcx_rle_pkg::cmd_t          cmd_o
);

  // Stall while the queue has no room; push every accepted request.
  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  // Split the byte into run-header flag, count and pixel value.
  always_comb begin
    cmd_o.start   = in_item_i.start_of_image;
    cmd_o.is_mark = (in_item_i.data_byte & pcx_rle_pkg::RUN_MARK) == pcx_rle_pkg::RUN_MARK;
    cmd_o.count   = pcx_rle_pkg::COUNT_W'(in_item_i.data_byte & pcx_rle_pkg::RUN_COUNT_MASK);
    cmd_o.value   = in_item_i.data_byte;
  end

endmodule

### design/pcx_rle_queue.sv
// Short command queue between the decoder front and back.
// Depends on pcx_rle_pkg for the command type and depth.
module pcx_rle_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  pcx_rle_pkg::cmd_t          cmd_i,
  input  logic                       pop_i,
  output pcx_rle_pkg::cmd_t          cmd_o,
  output pcx_rle_pkg::queue_status_t status_o
);

  localparam int unsigned Depth = pcx_rle_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  pcx_rle_pkg::cmd_t entry_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign do_push = push_i && (count_q != CntW'(Depth));
  assign do_pop  = pop_i && (count_q != '0);

  // Advance pointers with wrap and track the fill level.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed command.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o          = entry_q[rd_ptr_q];
  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.valid = (count_q != '0);

endmodule

### design/pcx_rle_back.sv
// Back part of the PCX decoder: runs the decode state, walks rows and columns
// and emits pixel writes through an output register. Depends on pcx_rle_pkg.
module pcx_rle_back #(
  parameter int unsigned MAX_WIDTH  = pcx_rle_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = pcx_rle_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pcx_rle_pkg::cfg_t          cfg_i,
  input  pcx_rle_pkg::cmd_t          cmd_i,
  input  pcx_rle_pkg::queue_status_t q_status_i,
  output logic                       pop_o,
  output pcx_rle_pkg::out_item_t     out_item_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned PW = WW + 1;
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned AW = pcx_rle_pkg::ADDR_W;
  localparam int unsigned SW = ((RW + PW) > AW) ? (RW + PW) : AW;
  localparam int unsigned NW = pcx_rle_pkg::COUNT_W;

  // Effective geometry, registered from the raw configuration.
  logic [WW-1:0] w_eff_q, w_eff_c;
  logic [PW-1:0] pitch_q, pitch_c, pitch_sum;
  logic [RW-1:0] hm1_q, hm1_c;
  logic [HW-1:0] h_eff_c;

  // Decode state.
  logic          awaiting_q, awaiting_d;
  logic [NW-1:0] pend_q, pend_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          finished_q, finished_d;
  logic          active_q, active_d;
  logic [NW-1:0] left_q, left_d;
  logic [pcx_rle_pkg::BYTE_W-1:0] val_q, val_d;

  // Output register.
  logic                   out_valid_q, out_valid_d;
  pcx_rle_pkg::out_item_t out_q, out_d;

  // Emission path.
  logic                           adv, emit, done, last;
  logic [CW-1:0]                  e_col;
  logic [RW-1:0]                  e_row;
  logic [NW-1:0]                  e_n;
  logic [pcx_rle_pkg::BYTE_W-1:0] e_val;
  logic [WW-1:0]                  col_inc;
  logic [SW-1:0]                  addr_full;

  // Clamp width and height, round the pitch up to a multiple of four bytes.
  always_comb begin
    if (cfg_i.image_width == '0) begin
      w_eff_c = WW'(1);
    end else if (32'(cfg_i.image_width) > MAX_WIDTH) begin
      w_eff_c = WW'(MAX_WIDTH);
    end else begin
      w_eff_c = WW'(cfg_i.image_width);
    end
    if (cfg_i.image_height == '0) begin
      h_eff_c = HW'(1);
    end else if (32'(cfg_i.image_height) > MAX_HEIGHT) begin
      h_eff_c = HW'(MAX_HEIGHT);
    end else begin
      h_eff_c = HW'(cfg_i.image_height);
    end
    pitch_sum = PW'(w_eff_c) + PW'(3);
    pitch_c   = {pitch_sum[PW-1:2], 2'b00};
    hm1_c     = RW'(h_eff_c - HW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_eff_q <= WW'(1);
      pitch_q <= PW'(4);
      hm1_q   <= '0;
    end else begin
      w_eff_q <= w_eff_c;
      pitch_q <= pitch_c;
      hm1_q   <= hm1_c;
    end
  end

  // Pick the next pixel: continue a run, or pop and decode a command.
  always_comb begin
    adv        = !out_valid_q || !out_stall_i;
    pop_o      = 1'b0;
    emit       = 1'b0;
    e_row      = row_q;
    e_col      = col_q;
    e_val      = val_q;
    e_n        = left_q;
    awaiting_d = awaiting_q;
    pend_d     = pend_q;
    finished_d = finished_q;
    row_d      = row_q;
    col_d      = col_q;
    active_d   = active_q;
    left_d     = left_q;
    val_d      = val_q;
    done       = 1'b0;
    last       = 1'b0;
    col_inc    = '0;
    out_d      = out_q;

    if (adv) begin
      if (active_q) begin
        emit = 1'b1;
      end else if (q_status_i.valid) begin
        pop_o = 1'b1;
        // Restart at the top stored row and drop any pending header.
        if (cmd_i.start) begin
          awaiting_d = 1'b0;
          pend_d     = '0;
          finished_d = 1'b0;
          e_col      = '0;
          e_row      = hm1_q;
        end
        if (!finished_d) begin
          if (awaiting_d) begin
            awaiting_d = 1'b0;
            e_n        = pend_d;
            pend_d     = '0;
            e_val      = cmd_i.value;
            emit       = (e_n != '0);
          end else if (cmd_i.is_mark) begin
            awaiting_d = 1'b1;
            pend_d     = cmd_i.count;
          end else begin
            e_n   = NW'(1);
            e_val = cmd_i.value;
            emit  = 1'b1;
          end
        end
        row_d = e_row;
        col_d = e_col;
      end

      // Step the column, wrap rows bottom-up, flag completion.
      if (emit) begin
        col_inc = WW'(e_col) + WW'(1);
        if (col_inc >= w_eff_q) begin
          col_d = '0;
          if (e_row == '0) begin
            done       = 1'b1;
            finished_d = 1'b1;
          end else begin
            row_d = e_row - RW'(1);
          end
        end else begin
          col_d = CW'(col_inc);
        end
        last     = done || (e_n == NW'(1));
        active_d = !last;
        left_d   = e_n - NW'(1);
        val_d    = e_val;
        out_d.pixel_address = addr_full[AW-1:0];
        out_d.pixel_value   = e_val;
        out_d.run_last      = last;
        out_d.image_done    = done;
      end
    end
    out_valid_d = adv ? emit : out_valid_q;
  end

  // Row base plus column, kept to the address width.
  assign addr_full = SW'(e_row) * SW'(pitch_q) + SW'(e_col);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q  <= 1'b0;
      pend_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      finished_q  <= 1'b1;
      active_q    <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      awaiting_q  <= awaiting_d;
      pend_q      <= pend_d;
      col_q       <= col_d;
      row_q       <= row_d;
      finished_q  <= finished_d;
      active_q    <= active_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the run value and the pending write.
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    out_q <= out_d;
  end

  assign out_item_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

### design/pcx_rle_chk.sv
// Port-level checker for the PCX decoder, bound to the top level.
// Depends on pcx_rle_pkg and on the pcx_rle_pixel_decoder ports.
module pcx_rle_chk (
  input logic                   clk_i,
  input logic                   rst_ni,
  input pcx_rle_pkg::out_item_t out_item_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i
);

  // Hold a stalled write unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled pixel write changed");

  // End of image always closes the run.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.image_done |-> out_item_o.run_last)
    else $error("image_done without run_last");

  // Keep the value across a run: the next write follows at once.
  a_run_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_item_o.run_last |=>
      out_valid_o && (out_item_o.pixel_value == $past(out_item_o.pixel_value)))
    else $error("run broken or value changed within run");

  // Drop all writes while in reset.
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("pixel write shown during reset");

endmodule

bind pcx_rle_pixel_decoder pcx_rle_chk u_pcx_rle_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_item_o  (out_item_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);
